### sv/tpi_pkg.sv
// Shared types and constants for the three-plane intersection block.
`timescale 1ns / 1ps
package tpi_pkg;

   // Fraction bits of the output coordinates (Q16.16 at the default width)
   localparam int OUT_FRAC = 16;

   // Sideband that travels with each quotient lane
   typedef struct packed {
      logic neg;
      logic singular;
   } side_type;

endpackage

### sv/three_plane_intersection.sv
// Three-plane intersection by Cramer's rule, fully pipelined top level.
//
// Usage: present a plane triple (normals and offsets, signed Q4.12) on the
// req_ channel; the common point comes back on the rsp_ channel as signed
// Q16.16 coordinates with singular and clipped flags.
// A zero determinant gives singular = 1, zero coordinates and clipped = 0.
// Pipeline: 5 front stages for products and sums, OUT_WIDTH + 2 divider
// stages with one quotient bit each, and one output register, from accepted
// request to valid response.
// Throughput: one transfer per cycle; a new request is taken each cycle
// while the response side keeps up.
// Stall: when rsp_valid is high and rsp_ready low, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// Reset: synchronous, active high; clears all valid bits, no result pending.
`timescale 1ns / 1ps
module three_plane_intersection #(
   parameter int IN_WIDTH  = 16,
   parameter int OUT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [IN_WIDTH-1:0]  req_a_nx,
   input  logic signed [IN_WIDTH-1:0]  req_a_ny,
   input  logic signed [IN_WIDTH-1:0]  req_a_nz,
   input  logic signed [IN_WIDTH-1:0]  req_a_dist,
   input  logic signed [IN_WIDTH-1:0]  req_b_nx,
   input  logic signed [IN_WIDTH-1:0]  req_b_ny,
   input  logic signed [IN_WIDTH-1:0]  req_b_nz,
   input  logic signed [IN_WIDTH-1:0]  req_b_dist,
   input  logic signed [IN_WIDTH-1:0]  req_c_nx,
   input  logic signed [IN_WIDTH-1:0]  req_c_ny,
   input  logic signed [IN_WIDTH-1:0]  req_c_nz,
   input  logic signed [IN_WIDTH-1:0]  req_c_dist,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_WIDTH-1:0] rsp_point_x,
   output logic signed [OUT_WIDTH-1:0] rsp_point_y,
   output logic signed [OUT_WIDTH-1:0] rsp_point_z,
   output logic                        rsp_singular,
   output logic                        rsp_clipped
);

   localparam int SW = 3 * IN_WIDTH + 4;

   logic                 en;
   logic                 front_valid;
   logic [SW-1:0]        num_mag [3];
   logic [SW-1:0]        den_mag;
   tpi_pkg::side_type    front_side [3];
   logic                 div_valid [3];
   logic [OUT_WIDTH+1:0] quo [3];
   tpi_pkg::side_type    div_side [3];
   logic [OUT_WIDTH-1:0] rnd_point [3];
   logic                 rnd_clip [3];

   logic                 rsp_valid_ff;
   logic [OUT_WIDTH-1:0] point_ff [3];
   logic                 singular_ff;
   logic                 clipped_ff;

   // Whole pipeline advances unless a finished result is waiting
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   tpi_front #(.IN_WIDTH(IN_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .a_nx      (req_a_nx),
      .a_ny      (req_a_ny),
      .a_nz      (req_a_nz),
      .a_dist    (req_a_dist),
      .b_nx      (req_b_nx),
      .b_ny      (req_b_ny),
      .b_nz      (req_b_nz),
      .b_dist    (req_b_dist),
      .c_nx      (req_c_nx),
      .c_ny      (req_c_ny),
      .c_nz      (req_c_nz),
      .c_dist    (req_c_dist),
      .out_valid (front_valid),
      .num_mag   (num_mag),
      .den_mag   (den_mag),
      .side      (front_side)
   );

   // One divider lane and one rounding unit per coordinate
   for (genvar k = 0; k < 3; k++) begin : g_lane
      tpi_divider #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (front_valid),
         .num_mag   (num_mag[k]),
         .den_mag   (den_mag),
         .in_side   (front_side[k]),
         .out_valid (div_valid[k]),
         .quo       (quo[k]),
         .out_side  (div_side[k])
      );

      tpi_round #(.OUT_WIDTH(OUT_WIDTH)) u_round (
         .quo   (quo[k]),
         .neg   (div_side[k].neg),
         .point (rnd_point[k]),
         .clip  (rnd_clip[k])
      );
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            point_ff[k] <= div_side[0].singular ? '0 : rnd_point[k];
         end
         singular_ff <= div_side[0].singular;
         clipped_ff  <= !div_side[0].singular
                        && (rnd_clip[0] || rnd_clip[1] || rnd_clip[2]);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_point_x  = point_ff[0];
   assign rsp_point_y  = point_ff[1];
   assign rsp_point_z  = point_ff[2];
   assign rsp_singular = singular_ff;
   assign rsp_clipped  = clipped_ff;

   // A singular result carries zero coordinates and no clip
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0 && !rsp_clipped)
      else $error("singular result with nonzero payload");

   // A clipped result has at least one coordinate at a range limit
   a_clip_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_point_x == {1'b0, {(OUT_WIDTH-1){1'b1}}}
         || rsp_point_x == {1'b1, {(OUT_WIDTH-1){1'b0}}}
         || rsp_point_y == {1'b0, {(OUT_WIDTH-1){1'b1}}}
         || rsp_point_y == {1'b1, {(OUT_WIDTH-1){1'b0}}}
         || rsp_point_z == {1'b0, {(OUT_WIDTH-1){1'b1}}}
         || rsp_point_z == {1'b1, {(OUT_WIDTH-1){1'b0}}})
      else $error("clipped result without a saturated coordinate");

   // Divider lanes stay in lockstep
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      div_valid[0] == div_valid[1] && div_valid[0] == div_valid[2])
      else $error("divider lanes out of step");

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

### sv/tpi_front.sv
// Front pipeline: cross products, determinant, numerators, magnitudes and signs.
`timescale 1ns / 1ps
module tpi_front #(
   parameter int IN_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic signed [IN_WIDTH-1:0] a_nx,
   input  logic signed [IN_WIDTH-1:0] a_ny,
   input  logic signed [IN_WIDTH-1:0] a_nz,
   input  logic signed [IN_WIDTH-1:0] a_dist,
   input  logic signed [IN_WIDTH-1:0] b_nx,
   input  logic signed [IN_WIDTH-1:0] b_ny,
   input  logic signed [IN_WIDTH-1:0] b_nz,
   input  logic signed [IN_WIDTH-1:0] b_dist,
   input  logic signed [IN_WIDTH-1:0] c_nx,
   input  logic signed [IN_WIDTH-1:0] c_ny,
   input  logic signed [IN_WIDTH-1:0] c_nz,
   input  logic signed [IN_WIDTH-1:0] c_dist,
   output logic                       out_valid,
   output logic [3*IN_WIDTH+3:0]      num_mag [3],
   output logic [3*IN_WIDTH+3:0]      den_mag,
   output tpi_pkg::side_type          side [3]
);

   localparam int W  = IN_WIDTH;
   localparam int PW = 2 * W;       // pairwise product
   localparam int CW = 2 * W + 1;   // cross product component
   localparam int TW = 3 * W + 1;   // weighted term
   localparam int SW = 3 * W + 4;   // sums and magnitudes

   // Operands of the eighteen pairwise products: bc, ca, ab cross products
   logic signed [W-1:0] pos_l [9];
   logic signed [W-1:0] pos_r [9];
   logic signed [W-1:0] neg_l [9];
   logic signed [W-1:0] neg_r [9];

   always_comb begin
      pos_l[0] = b_ny; pos_r[0] = c_nz; neg_l[0] = b_nz; neg_r[0] = c_ny;
      pos_l[1] = b_nz; pos_r[1] = c_nx; neg_l[1] = b_nx; neg_r[1] = c_nz;
      pos_l[2] = b_nx; pos_r[2] = c_ny; neg_l[2] = b_ny; neg_r[2] = c_nx;
      pos_l[3] = c_ny; pos_r[3] = a_nz; neg_l[3] = c_nz; neg_r[3] = a_ny;
      pos_l[4] = c_nz; pos_r[4] = a_nx; neg_l[4] = c_nx; neg_r[4] = a_nz;
      pos_l[5] = c_nx; pos_r[5] = a_ny; neg_l[5] = c_ny; neg_r[5] = a_nx;
      pos_l[6] = a_ny; pos_r[6] = b_nz; neg_l[6] = a_nz; neg_r[6] = b_ny;
      pos_l[7] = a_nz; pos_r[7] = b_nx; neg_l[7] = a_nx; neg_r[7] = b_nz;
      pos_l[8] = a_nx; pos_r[8] = b_ny; neg_l[8] = a_ny; neg_r[8] = b_nx;
   end

   logic [4:0] v_ff;

   logic signed [PW-1:0] pp_a_ff   [9];
   logic signed [PW-1:0] pn_a_ff   [9];
   logic signed [W-1:0]  an_a_ff   [3];
   logic signed [W-1:0]  dist_a_ff [3];

   logic signed [CW-1:0] cross_b_ff [9];
   logic signed [W-1:0]  an_b_ff    [3];
   logic signed [W-1:0]  dist_b_ff  [3];

   logic signed [TW-1:0] dterm_c_ff [3];
   logic signed [TW-1:0] tterm_c_ff [9];

   logic signed [SW-1:0] det_d_ff;
   logic signed [SW-1:0] top_d_ff [3];

   logic [SW-1:0]        num_e_ff [3];
   logic [SW-1:0]        den_e_ff;
   tpi_pkg::side_type    side_e_ff [3];

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   // Stage A: pairwise products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            pp_a_ff[i] <= pos_l[i] * pos_r[i];
            pn_a_ff[i] <= neg_l[i] * neg_r[i];
         end
         an_a_ff[0]   <= a_nx;
         an_a_ff[1]   <= a_ny;
         an_a_ff[2]   <= a_nz;
         dist_a_ff[0] <= a_dist;
         dist_a_ff[1] <= b_dist;
         dist_a_ff[2] <= c_dist;
      end
   end

   // Stage B: cross product components
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            cross_b_ff[i] <= CW'(pp_a_ff[i]) - CW'(pn_a_ff[i]);
         end
         an_b_ff   <= an_a_ff;
         dist_b_ff <= dist_a_ff;
      end
   end

   // Stage C: determinant terms a.(b x c) and offset-weighted cross products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dterm_c_ff[i] <= an_b_ff[i] * cross_b_ff[i];
         end
         for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
               tterm_c_ff[p*3+k] <= dist_b_ff[p] * cross_b_ff[p*3+k];
            end
         end
      end
   end

   // Stage D: sums; the numerator is negated
   always_ff @(posedge clock) begin
      if (en) begin
         det_d_ff <= SW'(dterm_c_ff[0]) + SW'(dterm_c_ff[1]) + SW'(dterm_c_ff[2]);
         for (int k = 0; k < 3; k++) begin
            top_d_ff[k] <= -(SW'(tterm_c_ff[k]) + SW'(tterm_c_ff[3+k])
                             + SW'(tterm_c_ff[6+k]));
         end
      end
   end

   // Stage E: magnitudes, quotient signs, zero determinant
   always_ff @(posedge clock) begin
      if (en) begin
         den_e_ff <= det_d_ff[SW-1] ? SW'(-det_d_ff) : SW'(det_d_ff);
         for (int k = 0; k < 3; k++) begin
            num_e_ff[k]           <= top_d_ff[k][SW-1] ? SW'(-top_d_ff[k])
                                                      : SW'(top_d_ff[k]);
            side_e_ff[k].neg      <= top_d_ff[k][SW-1] ^ det_d_ff[SW-1];
            side_e_ff[k].singular <= (det_d_ff == '0);
         end
      end
   end

   assign out_valid = v_ff[4];
   assign num_mag   = num_e_ff;
   assign den_mag   = den_e_ff;
   assign side      = side_e_ff;

endmodule

### sv/tpi_divider.sv
// Pipelined restoring divider: one quotient bit per stage, overflow bit first.
`timescale 1ns / 1ps
module tpi_divider #(
   parameter int IN_WIDTH  = 16,
   parameter int OUT_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [3*IN_WIDTH+3:0]     num_mag,
   input  logic [3*IN_WIDTH+3:0]     den_mag,
   input  tpi_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [OUT_WIDTH+1:0]      quo,
   output tpi_pkg::side_type         out_side
);

   localparam int SW = 3 * IN_WIDTH + 4;
   localparam int ST = OUT_WIDTH + 2;     // quotient bits incl. overflow
   localparam int RW = SW + OUT_WIDTH + 2;

   logic [RW-1:0]     rem_ff  [ST];
   logic [SW-1:0]     den_ff  [ST];
   logic [ST-1:0]     quo_ff  [ST];
   logic              v_ff    [ST];
   tpi_pkg::side_type side_ff [ST];

   for (genvar s = 0; s < ST; s++) begin : g_stage
      logic [RW-1:0]     src_rem;
      logic [SW-1:0]     src_den;
      logic [ST-1:0]     src_quo;
      logic              src_v;
      tpi_pkg::side_type src_side;
      logic [RW:0]       trial;
      logic [RW-1:0]     rem_in;
      logic              bit_in;

      if (s == 0) begin : g_first
         assign src_rem  = RW'(num_mag) << (tpi_pkg::OUT_FRAC + 1);
         assign src_den  = den_mag;
         assign src_quo  = '0;
         assign src_v    = in_valid;
         assign src_side = in_side;
      end else begin : g_next
         assign src_rem  = rem_ff[s-1];
         assign src_den  = den_ff[s-1];
         assign src_quo  = quo_ff[s-1];
         assign src_v    = v_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      // Trial subtract of the divisor aligned to this quotient bit
      assign trial  = {1'b0, src_rem} - ((RW+1)'(src_den) << (ST - 1 - s));
      assign bit_in = ~trial[RW];
      assign rem_in = bit_in ? trial[RW-1:0] : src_rem;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= src_den;
            quo_ff[s]  <= {src_quo[ST-2:0], bit_in};
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = v_ff[ST-1];
   assign quo       = quo_ff[ST-1];
   assign out_side  = side_ff[ST-1];

endmodule

### sv/tpi_round.sv
// Round to nearest (ties away from zero), saturate and apply sign for one coordinate.
`timescale 1ns / 1ps
module tpi_round #(
   parameter int OUT_WIDTH = 32
) (
   input  logic [OUT_WIDTH+1:0] quo,
   input  logic                 neg,
   output logic [OUT_WIDTH-1:0] point,
   output logic                 clip
);

   localparam int O = OUT_WIDTH;

   logic [O+1:0] inc;
   logic [O:0]   mag;
   logic [O:0]   limit;

   // quo holds the overflow bit over one extra fraction bit
   always_comb begin
      inc   = {1'b0, quo[O:0]} + (O+2)'(1);
      mag   = inc[O+1:1];
      limit = ((O+1)'(1) << (O - 1)) - (neg ? (O+1)'(0) : (O+1)'(1));
      clip  = quo[O+1] || (mag > limit);
      if (clip) begin
         point = neg ? {1'b1, {(O-1){1'b0}}} : {1'b0, {(O-1){1'b1}}};
      end else begin
         point = neg ? O'(-mag[O-1:0]) : mag[O-1:0];
      end
   end

endmodule

### tb/tb_three_plane_intersection.sv
// Self-checking testbench for the three-plane intersection block.
`timescale 1ns / 1ps
module tb_three_plane_intersection;

   localparam int IN_W      = 16;
   localparam int OUT_W     = 32;
   localparam int FRAC      = tpi_pkg::OUT_FRAC;
   localparam int LATENCY   = OUT_W + 8;
   localparam int N_RANDOM  = 1930;
   localparam int CYCLE_CAP = 400000;
   localparam int TAIL_ITEMS = 150;

   typedef logic signed [IN_W-1:0] coef_type;

   typedef struct {
      coef_type f[12];
   } triple_type;

   typedef struct {
      logic signed [OUT_W-1:0] x, y, z;
      logic                    singular, clipped;
   } point_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   coef_type req_f[12];
   logic signed [OUT_W-1:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic rsp_singular, rsp_clipped;

   triple_type pending_triples[$];
   point_type  expected_points[$];
   int      n_sent, n_checked, n_errors, n_singular, n_clipped;
   int      cycle_count;
   bit      all_queued, quiet_tail, hold_rsp;
   int      req_gap, rsp_gap, hold_count;

   three_plane_intersection #(.IN_WIDTH(IN_W), .OUT_WIDTH(OUT_W)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_nx(req_f[0]), .req_a_ny(req_f[1]), .req_a_nz(req_f[2]),
      .req_a_dist(req_f[3]),
      .req_b_nx(req_f[4]), .req_b_ny(req_f[5]), .req_b_nz(req_f[6]),
      .req_b_dist(req_f[7]),
      .req_c_nx(req_f[8]), .req_c_ny(req_f[9]), .req_c_nz(req_f[10]),
      .req_c_dist(req_f[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_point_z(rsp_point_z),
      .rsp_singular(rsp_singular), .rsp_clipped(rsp_clipped)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Rounded, saturated num * 2^FRAC / den (den nonzero)
   function automatic logic signed [OUT_W-1:0] scaled_quotient(
      input longint num, input longint den, inout logic clip);
      logic         neg;
      logic [127:0] n, d, q, rem, mag, lim;
      neg = (num < 0) != (den < 0);
      n   = (num < 0) ? -num : num;
      d   = (den < 0) ? -den : den;
      q   = (n << (FRAC + 1)) / d;
      rem = q[0];
      mag = (q >> 1) + rem;
      lim = neg ? (128'd1 << (OUT_W - 1)) : ((128'd1 << (OUT_W - 1)) - 1);
      if (mag > lim) begin
         mag  = lim;
         clip = 1'b1;
      end
      return neg ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
   endfunction

   // Cramer's rule on exact integer products
   function automatic point_type intersect_planes(input triple_type t);
      longint ax, ay, az, ad, bx, by, bz, bd, cx, cy, cz, cd, det, tx, ty, tz;
      point_type p;
      logic   clip;
      ax = t.f[0]; ay = t.f[1]; az = t.f[2];  ad = t.f[3];
      bx = t.f[4]; by = t.f[5]; bz = t.f[6];  bd = t.f[7];
      cx = t.f[8]; cy = t.f[9]; cz = t.f[10]; cd = t.f[11];
      det = ax*by*cz + ay*bz*cx + az*bx*cy - ax*bz*cy - ay*bx*cz - az*by*cx;
      tx = -(ad*(by*cz - bz*cy) + bd*(cy*az - cz*ay) + cd*(ay*bz - az*by));
      ty = -(ad*(bz*cx - bx*cz) + bd*(cz*ax - cx*az) + cd*(az*bx - ax*bz));
      tz = -(ad*(bx*cy - by*cx) + bd*(cx*ay - cy*ax) + cd*(ax*by - ay*bx));
      clip = 1'b0;
      p.singular = (det == 0);
      if (det == 0) begin
         p.x = '0; p.y = '0; p.z = '0;
      end else begin
         p.x = scaled_quotient(tx, det, clip);
         p.y = scaled_quotient(ty, det, clip);
         p.z = scaled_quotient(tz, det, clip);
      end
      p.clipped = clip;
      return p;
   endfunction

   function automatic coef_type rand_coef();
      case ($urandom_range(0, 5))
         0: return coef_type'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
         1: return coef_type'($signed($urandom_range(0, 64)) - 32);
         2: return coef_type'($signed($urandom_range(0, 8192)) - 4096);
         default: return coef_type'($urandom);
      endcase
   endfunction

   task automatic queue_triple(input triple_type t);
      pending_triples.push_back(t);
   endtask

   task automatic queue_uniform(input coef_type v);
      triple_type t;
      foreach (t.f[i]) t.f[i] = v;
      queue_triple(t);
   endtask

   // Axis-aligned planes: x = -ad/nx etc.
   task automatic queue_axes(input coef_type nx, ny, nz, ad, bd, cd);
      triple_type t;
      foreach (t.f[i]) t.f[i] = '0;
      t.f[0] = nx; t.f[3] = ad;
      t.f[5] = ny; t.f[7] = bd;
      t.f[10] = nz; t.f[11] = cd;
      queue_triple(t);
   endtask

   // Stimulus: directed corners, then random triples
   initial begin
      triple_type t;
      all_queued = 0;
      queue_uniform(16'sh0000);
      queue_uniform(16'sh7fff);
      queue_uniform(-16'sh8000);
      queue_axes(16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000, -16'sh2000, 16'sh3000);
      queue_axes(16'sh0001, 16'sh0001, 16'sh0001, 16'sh7fff, -16'sh8000, 16'sh7fff);
      queue_axes(16'sh0001, -16'sh0001, 16'sh0001, -16'sh8000, 16'sh7fff, -16'sh8000);
      queue_axes(-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      queue_axes(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh0001);
      queue_axes(16'sh0003, 16'sh0003, 16'sh0003, 16'sh0001, 16'sh0002, -16'sh0001);
      queue_axes(16'sh0002, 16'sh0002, 16'sh0002, 16'sh0001, -16'sh0001, 16'sh0003);
      queue_axes(16'sh0003, 16'sh0007, 16'sh000b, -16'sh0001, 16'sh0005, 16'sh0004);
      queue_axes(16'sh1000, 16'sh0000, 16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000);
      // two parallel planes: singular, with random offsets
      foreach (t.f[i]) t.f[i] = rand_coef();
      t.f[4] = t.f[0]; t.f[5] = t.f[1]; t.f[6] = t.f[2];
      queue_triple(t);
      // mixed-sign full-scale patterns
      for (int k = 0; k < 8; k++) begin
         foreach (t.f[i]) t.f[i] = ((i + k) % 3 == 0) ? -16'sh8000 :
                                   ((i + k) % 3 == 1) ? 16'sh7fff : 16'sh0001;
         queue_triple(t);
      end
      for (int k = 0; k < N_RANDOM; k++) begin
         foreach (t.f[i]) t.f[i] = rand_coef();
         // some degenerate triples: a repeated normal
         if ($urandom_range(0, 15) == 0) begin
            t.f[8] = t.f[0]; t.f[9] = t.f[1]; t.f[10] = t.f[2];
         end
         queue_triple(t);
      end
      all_queued = 1;
   end

   // Driver: random bursts of idle, none near the end
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
         foreach (req_f[i]) req_f[i] <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_points.push_back(intersect_planes(
               triple_type'{f: req_f}));
            n_sent <= n_sent + 1;
         end
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_triples.size() > 0) begin
            triple_type t;
            t = pending_triples.pop_front();
            if (!quiet_tail && $urandom_range(0, 9) == 0)
               req_gap <= $urandom_range(1, 12);
            foreach (req_f[i]) req_f[i] <= t.f[i];
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted in cycles, to back up the pipe
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
         hold_rsp   <= 1'b0;
      end else if (hold_rsp) begin
         hold_count <= hold_count + 1;
         if (hold_count >= 3 * LATENCY) hold_rsp <= 1'b0;
      end else if (n_sent == 300 && hold_count == 0) begin
         hold_rsp <= 1'b1;
      end
   end

   // Receiver: random stalls, held off while the long hold runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (hold_rsp || (n_sent == 300 && hold_count == 0)) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet_tail && $urandom_range(0, 9) == 0)
            rsp_gap <= $urandom_range(1, 12);
      end
   end

   // Monitor: compare each response transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $error("response with nothing expected");
            n_errors <= n_errors + 1;
         end else begin
            point_type e;
            int     bad;
            e   = expected_points.pop_front();
            bad = 0;
            if (rsp_point_x !== e.x) begin
               $error("point_x expected %0d got %0d", e.x, rsp_point_x); bad++;
            end
            if (rsp_point_y !== e.y) begin
               $error("point_y expected %0d got %0d", e.y, rsp_point_y); bad++;
            end
            if (rsp_point_z !== e.z) begin
               $error("point_z expected %0d got %0d", e.z, rsp_point_z); bad++;
            end
            if (rsp_singular !== e.singular) begin
               $error("singular expected %0b got %0b", e.singular, rsp_singular); bad++;
            end
            if (rsp_clipped !== e.clipped) begin
               $error("clipped expected %0b got %0b", e.clipped, rsp_clipped); bad++;
            end
            n_errors   <= n_errors + bad;
            n_checked  <= n_checked + 1;
            n_singular <= n_singular + e.singular;
            n_clipped  <= n_clipped + e.clipped;
         end
      end
   end

   // Reset, quiet tail, end of run and cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset = 1; quiet_tail = 0; cycle_count = 0;
      n_sent = 0; n_checked = 0; n_errors = 0; n_singular = 0; n_clipped = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      wait (all_queued);
      wait (pending_triples.size() < TAIL_ITEMS);
      quiet_tail = 1;
      wait (pending_triples.size() == 0 && !req_valid);
      wait (expected_points.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("checked %0d of %0d plane triples: %0d singular, %0d clipped",
               n_checked, n_sent, n_singular, n_clipped);
      if (n_errors == 0 && expected_points.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
